// ===== src/load_cell_tare_and_weigh_core_defines.svh =====
// assertion macros shared by the load cell core checkers
`ifndef LOAD_CELL_TARE_AND_WEIGH_CORE_DEFINES_SVH
`define LOAD_CELL_TARE_AND_WEIGH_CORE_DEFINES_SVH

// same-cycle implication
`define LCTW_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define LCTW_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== src/lctw_pkg.sv =====
// package with constants, codes and helpers for the load cell tare and weigh core
package lctw_pkg;

  localparam int MAX_TARE = 64;
  localparam int ADDR_W   = $clog2(MAX_TARE);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int RAW_W    = 24;
  localparam int FRAC_W   = 16;
  localparam int ACC_W    = RAW_W + ADDR_W + 1;
  localparam int DIV_W    = ACC_W;
  localparam int DEN_W    = 17;
  localparam int STEP_W   = $clog2(DIV_W);
  localparam int PROD_W   = 42;
  localparam int WGT_W    = 25;

  localparam logic [1:0] REG_TARE_COUNT    = 2'd0;
  localparam logic [1:0] REG_HALF_SPREAD   = 2'd1;
  localparam logic [1:0] REG_SCALE_DIVISOR = 2'd2;

  localparam logic [1:0] ST_WEIGHT    = 2'd0;
  localparam logic [1:0] ST_TARE_DONE = 2'd1;
  localparam logic [1:0] ST_TARE_FAIL = 2'd2;
  localparam logic [1:0] ST_STALE     = 2'd3;

  localparam logic [6:0]         TARE_COUNT_RST    = 7'd50;
  localparam logic [15:0]        HALF_SPREAD_RST   = 16'd328;
  localparam logic signed [15:0] SCALE_DIVISOR_RST = -16'sd600;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SUM      = 7'b0000010,
    S_DIV_MEAN = 7'b0000100,
    S_MUL      = 7'b0001000,
    S_SCAN     = 7'b0010000,
    S_DIV_OFF  = 7'b0100000,
    S_DIV_W    = 7'b1000000
  } state_t;

  // bits 6,4,2,0 of each byte, first byte first, msb first
  function automatic logic signed [RAW_W-1:0] decode_frame(input logic [47:0] f);
    logic [RAW_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 4; k++) begin
        acc[RAW_W-1-4*i-k] = f[46-8*i-2*k];
      end
    end
    return $signed(acc);
  endfunction

endpackage

// ===== src/load_cell_tare_and_weigh_core.sv =====
// load cell tare and weigh core: frame decode, tare collection, band filter, scaling
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+-------------------------
//  item in   | ready_byte, frame                       | start && !busy
//  result    | weight, tare_offset, status             | done, one cycle, no stall
//  config    | wr_index, wr_data                       | wr_en, every edge
//
//  a collecting item, or a stale one before the tare, ends in idle; a weight or stale
//  item after it runs the shared divider unless scale_divisor is zero; the item that
//  completes a tare of n samples makes two passes over the sample memory and one or
//  two runs of the 31-step divider (one if the tare fails). busy is high while an item
//  is at work. rst (synchronous) resets only the control registers; no clearing pass.
module load_cell_tare_and_weigh_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [7:0]          ready_byte,
  input  logic [47:0]         frame,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [15:0]         wr_data,
  output logic                done,
  output logic signed [24:0]  weight,
  output logic signed [23:0]  tare_offset,
  output logic [1:0]          status
);

  localparam int AW = lctw_pkg::ADDR_W;
  localparam int CW = lctw_pkg::CNT_W;
  localparam int RW = lctw_pkg::RAW_W;
  localparam int XW = lctw_pkg::ACC_W;
  localparam int DW = lctw_pkg::DIV_W;
  localparam int NW = lctw_pkg::DEN_W;
  localparam int SW = lctw_pkg::STEP_W;
  localparam int PW = lctw_pkg::PROD_W;
  localparam int FW = lctw_pkg::FRAC_W;
  localparam int WW = lctw_pkg::WGT_W;

  logic [6:0]           tare_count;
  logic [15:0]          half_spread;
  logic signed [15:0]   scale_divisor;

  lctw_pkg::state_t     state;

  logic signed [RW-1:0] sample_store [lctw_pkg::MAX_TARE];
  logic signed [RW-1:0] rd_data;
  logic                 mem_we;

  logic [CW-1:0]        stored_count;
  logic [CW-1:0]        tare_n;
  logic [CW-1:0]        issue_cnt;
  logic [CW-1:0]        hits;
  logic                 rd_valid;
  logic                 measuring;
  logic signed [RW-1:0] offset_reg;
  logic signed [RW-1:0] last_raw;
  logic signed [XW-1:0] acc;
  logic signed [RW-1:0] mean;
  logic signed [PW-1:0] bound_a;
  logic signed [PW-1:0] bound_b;
  logic                 mul_phase;
  logic [1:0]           status_hold;

  logic [DW-1:0]        dq;
  logic [NW-1:0]        den_mag;
  logic [NW-1:0]        rem;
  logic                 div_neg;
  logic [SW-1:0]        div_cnt;

  logic                 accept;
  logic                 is_ready;
  logic signed [RW-1:0] raw;
  logic signed [RW-1:0] raw_cur;
  logic [CW-1:0]        cnt_inc;
  logic [CW-1:0]        n_eff;
  logic signed [WW-1:0] diff;
  logic                 pass_end;
  logic                 div_load;
  logic                 div_run;
  logic signed [XW-1:0] load_num;
  logic signed [NW-1:0] load_den;
  logic [NW:0]          rem_sh;
  logic [NW+1:0]        trial;
  logic                 qbit;
  logic [DW-1:0]        q_last;
  logic signed [DW-1:0] q_res;
  logic                 div_last;
  logic signed [17:0]   factor;
  logic signed [PW-1:0] product;
  logic signed [PW-1:0] s_ext;
  logic signed [PW-1:0] lo;
  logic signed [PW-1:0] hi;
  logic                 in_band;

  assign busy     = (state != lctw_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign is_ready = (ready_byte == 8'd0);
  assign raw      = lctw_pkg::decode_frame(frame);
  assign raw_cur  = is_ready ? raw : last_raw;
  assign diff     = {raw_cur[RW-1], raw_cur} - {offset_reg[RW-1], offset_reg};
  assign mem_we   = accept && !measuring && is_ready
                    && (stored_count < CW'(lctw_pkg::MAX_TARE));
  assign cnt_inc  = (stored_count < CW'(lctw_pkg::MAX_TARE)) ? stored_count + 1'b1
                                                              : stored_count;

  always_comb begin
    if (tare_count == 7'd0) begin
      n_eff = CW'(1);
    end else if (32'(tare_count) > lctw_pkg::MAX_TARE) begin
      n_eff = CW'(lctw_pkg::MAX_TARE);
    end else begin
      n_eff = CW'(tare_count);
    end
  end

  assign pass_end = (issue_cnt == tare_n) && !rd_valid;

  // shared divider operands
  always_comb begin
    case (state)
      lctw_pkg::S_SUM: begin
        load_num = acc;
        load_den = NW'(tare_n);
      end
      lctw_pkg::S_SCAN: begin
        load_num = acc;
        load_den = NW'(hits);
      end
      default: begin
        load_num = XW'(diff);
        load_den = NW'(scale_divisor);
      end
    endcase
  end

  assign div_load = (state == lctw_pkg::S_IDLE && accept && measuring
                     && scale_divisor != 16'sd0)
                    || (state == lctw_pkg::S_SUM && pass_end)
                    || (state == lctw_pkg::S_SCAN && pass_end && hits != '0);
  assign div_run  = (state == lctw_pkg::S_DIV_MEAN) || (state == lctw_pkg::S_DIV_OFF)
                    || (state == lctw_pkg::S_DIV_W);

  assign rem_sh   = {rem, dq[DW-1]};
  assign trial    = {1'b0, rem_sh} - {2'b00, den_mag};
  assign qbit     = !trial[NW+1];
  assign q_last   = {dq[DW-2:0], qbit};
  assign q_res    = div_neg ? -$signed(q_last) : $signed(q_last);
  assign div_last = (div_cnt == SW'(DW - 1));

  assign factor  = mul_phase ? $signed({1'b0, 17'h10000 + {1'b0, half_spread}})
                             : $signed({1'b0, 17'h10000 - {1'b0, half_spread}});
  assign product = PW'(mean) * PW'(factor);

  assign s_ext   = {{(PW-RW-FW){rd_data[RW-1]}}, rd_data, {FW{1'b0}}};
  assign lo      = mean[RW-1] ? bound_b : bound_a;
  assign hi      = mean[RW-1] ? bound_a : bound_b;
  assign in_band = (s_ext > lo) && (s_ext < hi);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_store[stored_count[AW-1:0]] <= raw;
    end
    rd_data <= sample_store[issue_cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      dq      <= load_num[XW-1] ? DW'(-load_num) : DW'(load_num);
      den_mag <= load_den[NW-1] ? NW'(-load_den) : NW'(load_den);
      div_neg <= load_num[XW-1] ^ load_den[NW-1];
      rem     <= '0;
      div_cnt <= '0;
    end else if (div_run) begin
      dq      <= q_last;
      rem     <= qbit ? trial[NW-1:0] : rem_sh[NW-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lctw_pkg::S_IDLE;
      done          <= 1'b0;
      tare_count    <= lctw_pkg::TARE_COUNT_RST;
      half_spread   <= lctw_pkg::HALF_SPREAD_RST;
      scale_divisor <= lctw_pkg::SCALE_DIVISOR_RST;
      stored_count  <= '0;
      measuring     <= 1'b0;
      offset_reg    <= '0;
      last_raw      <= '0;
      rd_valid      <= 1'b0;
    end else begin
      done <= 1'b0;

      if (wr_en) begin
        unique case (wr_index)
          lctw_pkg::REG_TARE_COUNT:    tare_count    <= wr_data[6:0];
          lctw_pkg::REG_HALF_SPREAD:   half_spread   <= wr_data;
          lctw_pkg::REG_SCALE_DIVISOR: scale_divisor <= $signed(wr_data);
          default: ;
        endcase
      end

      unique case (state)
        lctw_pkg::S_IDLE: begin
          if (accept) begin
            last_raw <= raw_cur;
            if (!measuring) begin
              if (is_ready) begin
                stored_count <= cnt_inc;
                if (cnt_inc >= n_eff) begin
                  tare_n    <= n_eff;
                  issue_cnt <= '0;
                  rd_valid  <= 1'b0;
                  acc       <= '0;
                  state     <= lctw_pkg::S_SUM;
                end
              end
            end else begin
              status_hold <= is_ready ? lctw_pkg::ST_WEIGHT : lctw_pkg::ST_STALE;
              if (scale_divisor == 16'sd0) begin
                done        <= 1'b1;
                weight      <= diff;
                tare_offset <= offset_reg;
                status      <= is_ready ? lctw_pkg::ST_WEIGHT : lctw_pkg::ST_STALE;
              end else begin
                state <= lctw_pkg::S_DIV_W;
              end
            end
          end
        end

        lctw_pkg::S_SUM: begin
          rd_valid <= (issue_cnt < tare_n);
          if (issue_cnt < tare_n) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (rd_valid) begin
            acc <= acc + XW'(rd_data);
          end
          if (pass_end) begin
            state <= lctw_pkg::S_DIV_MEAN;
          end
        end

        lctw_pkg::S_DIV_MEAN: begin
          if (div_last) begin
            mean      <= q_res[RW-1:0];
            mul_phase <= 1'b0;
            state     <= lctw_pkg::S_MUL;
          end
        end

        lctw_pkg::S_MUL: begin
          if (!mul_phase) begin
            bound_a   <= product;
            mul_phase <= 1'b1;
          end else begin
            bound_b   <= product;
            issue_cnt <= '0;
            rd_valid  <= 1'b0;
            acc       <= '0;
            hits      <= '0;
            state     <= lctw_pkg::S_SCAN;
          end
        end

        lctw_pkg::S_SCAN: begin
          rd_valid <= (issue_cnt < tare_n);
          if (issue_cnt < tare_n) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (rd_valid && in_band) begin
            acc  <= acc + XW'(rd_data);
            hits <= hits + 1'b1;
          end
          if (pass_end) begin
            if (hits == '0) begin
              stored_count <= '0;
              done         <= 1'b1;
              weight       <= '0;
              tare_offset  <= offset_reg;
              status       <= lctw_pkg::ST_TARE_FAIL;
              state        <= lctw_pkg::S_IDLE;
            end else begin
              state <= lctw_pkg::S_DIV_OFF;
            end
          end
        end

        lctw_pkg::S_DIV_OFF: begin
          if (div_last) begin
            offset_reg  <= q_res[RW-1:0];
            measuring   <= 1'b1;
            done        <= 1'b1;
            weight      <= '0;
            tare_offset <= q_res[RW-1:0];
            status      <= lctw_pkg::ST_TARE_DONE;
            state       <= lctw_pkg::S_IDLE;
          end
        end

        lctw_pkg::S_DIV_W: begin
          if (div_last) begin
            done        <= 1'b1;
            weight      <= q_res[WW-1:0];
            tare_offset <= offset_reg;
            status      <= status_hold;
            state       <= lctw_pkg::S_IDLE;
          end
        end

        default: begin
          state <= lctw_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/lctw_checker.sv =====
// port-level checker for the load cell tare and weigh core, with its bind
`include "load_cell_tare_and_weigh_core_defines.svh"

module lctw_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [24:0] weight,
  input logic [1:0]         status
);

  // results only appear once the item's work is over
  `LCTW_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)

  // work only starts on a requested item
  `LCTW_ASSERT_IMP(a_busy_from_start, clk, rst, $rose(busy), $past(start))

  // tare results carry no weight
  `LCTW_ASSERT_IMP(a_tare_zero_weight, clk, rst,
    done && (status == lctw_pkg::ST_TARE_DONE || status == lctw_pkg::ST_TARE_FAIL),
    weight == 25'sd0)

  // an item is only taken on start, so idle with no start stays idle
  `LCTW_ASSERT_NXT(a_idle_stays_idle, clk, rst, !busy && !start, !busy)

endmodule

bind load_cell_tare_and_weigh_core lctw_checker u_lctw_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .weight (weight),
  .status (status)
);

// ===== sim/tb_top.sv =====
// self-checking testbench for the load cell tare and weigh core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  PAT_NOISE   = 0;
  localparam int  PAT_PAIRS   = 1;
  localparam int  PAT_CLUSTER = 2;
  localparam int  ITEM_TARGET = 1100;
  localparam int  SETTLE_CYC  = 8;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [24:0] weight;
    logic signed [23:0] offset;
    logic [1:0]         status;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [7:0]         ready_byte = '0;
  logic [47:0]        frame = '0;
  logic               wr_en = 1'b0;
  logic [1:0]         wr_index = lctw_pkg::REG_TARE_COUNT;
  logic [15:0]        wr_data = '0;
  logic               done;
  logic signed [24:0] weight;
  logic signed [23:0] tare_offset;
  logic [1:0]         status;

  // scale model state and its copy of the registers
  logic signed [23:0] tare_store [lctw_pkg::MAX_TARE];
  int unsigned        stored_n = 0;
  bit                 measuring = 1'b0;
  logic signed [23:0] offset_q = '0;
  logic signed [23:0] last_raw_q = '0;
  logic [6:0]         cfg_count = lctw_pkg::TARE_COUNT_RST;
  logic [15:0]        cfg_spread = lctw_pkg::HALF_SPREAD_RST;
  logic signed [15:0] cfg_scale = lctw_pkg::SCALE_DIVISOR_RST;

  reading_t pending_readings[$];
  int       errors = 0;
  int       items_sent = 0;
  bit       back_to_back = 1'b0;
  longint   cycles = 0;

  load_cell_tare_and_weigh_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .ready_byte  (ready_byte),
    .frame       (frame),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .done        (done),
    .weight      (weight),
    .tare_offset (tare_offset),
    .status      (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic note_error(string msg);
    $display("tb_top: %s", msg);
    errors++;
  endtask

  function automatic logic signed [23:0] raw_from_frame(logic [47:0] f);
    logic [23:0] acc;
    acc = '0;
    for (int i = 0; i < 6; i++) begin
      for (int b = 6; b >= 0; b -= 2) begin
        acc = {acc[22:0], f[40-8*i+b]};
      end
    end
    return $signed(acc);
  endfunction

  // odd bits of each byte are random filler
  function automatic logic [47:0] frame_for(logic [23:0] r);
    logic [47:0] f;
    f = {16'($urandom), 32'($urandom)};
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 4; k++) begin
        f[46-8*i-2*k] = r[23-4*i-k];
      end
    end
    return f;
  endfunction

  function automatic logic signed [23:0] clamp_raw(longint v);
    if (v > 8388607) v = 8388607;
    else if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic bit tare_from_store(int n, output logic signed [23:0] off);
    longint sum, sum_in, mean, lo, hi, t, s;
    int hits;
    sum = 0;
    sum_in = 0;
    hits = 0;
    off = '0;
    for (int i = 0; i < n; i++) sum += longint'(tare_store[i]);
    mean = sum / longint'(n);
    lo = mean * (65536 - longint'(cfg_spread));
    hi = mean * (65536 + longint'(cfg_spread));
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    for (int i = 0; i < n; i++) begin
      s = longint'(tare_store[i]) * 65536;
      if (s > lo && s < hi) begin
        sum_in += longint'(tare_store[i]);
        hits++;
      end
    end
    if (hits == 0) return 1'b0;
    t = sum_in / longint'(hits);
    off = t[23:0];
    return 1'b1;
  endfunction

  task automatic apply_poll(logic [7:0] rb, logic [47:0] fr);
    bit rdy;
    int n;
    logic signed [23:0] off;
    longint diff;
    reading_t r;
    rdy = (rb == 8'd0);
    if (rdy) last_raw_q = raw_from_frame(fr);
    if (!measuring) begin
      if (!rdy) return;
      if (stored_n < lctw_pkg::MAX_TARE) begin
        tare_store[stored_n] = last_raw_q;
        stored_n++;
      end
      n = (cfg_count < 1) ? 1
        : (cfg_count > lctw_pkg::MAX_TARE) ? lctw_pkg::MAX_TARE : int'(cfg_count);
      if (stored_n < n) return;
      r.weight = '0;
      if (tare_from_store(n, off)) begin
        offset_q = off;
        measuring = 1'b1;
        r.status = lctw_pkg::ST_TARE_DONE;
      end else begin
        stored_n = 0;
        r.status = lctw_pkg::ST_TARE_FAIL;
      end
      r.offset = offset_q;
      pending_readings.push_back(r);
      return;
    end
    diff = longint'(last_raw_q) - longint'(offset_q);
    if (cfg_scale != 0) diff = diff / longint'(cfg_scale);
    r.weight = diff[24:0];
    r.offset = offset_q;
    r.status = rdy ? lctw_pkg::ST_WEIGHT : lctw_pkg::ST_STALE;
    pending_readings.push_back(r);
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst && done) begin
      if (pending_readings.size() == 0) begin
        note_error($sformatf("result with nothing pending, status %0d weight %0d",
                             status, weight));
      end else begin
        want = pending_readings.pop_front();
        if (weight !== want.weight)
          note_error($sformatf("weight got %0d want %0d", weight, want.weight));
        if (tare_offset !== want.offset)
          note_error($sformatf("tare_offset got %0d want %0d", tare_offset, want.offset));
        if (status !== want.status)
          note_error($sformatf("status got %0d want %0d", status, want.status));
      end
    end
  end

  task automatic send_poll(logic [7:0] rb, logic [47:0] fr);
    @(negedge clk);
    start <= 1'b1;
    ready_byte <= rb;
    frame <= fr;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_poll(rb, fr);
    items_sent++;
  endtask

  task automatic send_ready(logic [23:0] r);
    send_poll(8'd0, frame_for(r));
  endtask

  task automatic send_stale();
    send_poll(8'($urandom_range(1, 255)), {16'($urandom), 32'($urandom)});
  endtask

  task automatic pause();
    int g;
    int r;
    g = 0;
    if (!back_to_back) begin
      r = $urandom_range(0, 99);
      if (r < 55) g = 0;
      else if (r < 85) g = $urandom_range(1, 3);
      else if (r < 98) g = $urandom_range(4, 20);
      else g = $urandom_range(40, 200);
    end
    if (g > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // hold off until every pending result is out and the core is idle
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      lctw_pkg::REG_TARE_COUNT:    cfg_count = val[6:0];
      lctw_pkg::REG_HALF_SPREAD:   cfg_spread = val;
      lctw_pkg::REG_SCALE_DIVISOR: cfg_scale = val;
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // one tare collection; stale items are mixed in
  task automatic collect_set(bit write_cfg, logic [6:0] count_val, logic [15:0] hs,
                             int pattern, longint base, bit outliers);
    int eff;
    longint k, s;
    logic signed [23:0] r;
    s = 0;
    k = ((base < 0) ? -base : base) >>> 12;
    if (write_cfg) begin
      drain();
      write_reg(lctw_pkg::REG_TARE_COUNT, {9'd0, count_val});
      write_reg(lctw_pkg::REG_HALF_SPREAD, hs);
    end
    eff = (count_val < 1) ? 1
        : (count_val > lctw_pkg::MAX_TARE) ? lctw_pkg::MAX_TARE : int'(count_val);
    for (int i = 0; i < eff; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_stale();
        pause();
      end
      case (pattern)
        PAT_PAIRS: begin
          if (i % 2 == 0) s = longint'($urandom_range(0, 16777214)) - 8388607;
          else s = -s;
          r = clamp_raw(s);
        end
        PAT_CLUSTER: begin
          if (outliers && $urandom_range(0, 7) == 0) r = 24'($urandom);
          else r = clamp_raw(base + longint'($urandom_range(0, 2 * k)) - k);
        end
        default: r = 24'($urandom);
      endcase
      send_ready(r);
      pause();
    end
  endtask

  task automatic test_default_tare();
    // mean of the pairs is zero so the band is empty
    collect_set(1'b0, lctw_pkg::TARE_COUNT_RST, lctw_pkg::HALF_SPREAD_RST, PAT_PAIRS, 0,
                1'b0);
  endtask

  task automatic test_frame_decode();
    logic [47:0] frames [6];
    frames[0] = 48'h0000_0000_0000;
    frames[1] = 48'hFFFF_FFFF_FFFF;
    frames[2] = 48'h5555_5555_5555;
    frames[3] = 48'hAAAA_AAAA_AAAA;
    frames[4] = 48'h4000_0000_0000;
    frames[5] = 48'h1555_5555_5555;
    drain();
    write_reg(lctw_pkg::REG_TARE_COUNT, 16'd1);
    write_reg(lctw_pkg::REG_HALF_SPREAD, 16'd0);
    for (int i = 0; i < 8; i++) begin
      send_poll(8'd1 << i, {16'($urandom), 32'($urandom)});
      pause();
      if (i < 6) begin
        send_poll(8'd0, frames[i]);
        pause();
      end
    end
  endtask

  task automatic test_count_zero();
    drain();
    write_reg(lctw_pkg::REG_TARE_COUNT, 16'd0);
    send_ready(24'($urandom));
    pause();
  endtask

  task automatic test_count_lowered();
    drain();
    write_reg(lctw_pkg::REG_TARE_COUNT, 16'd10);
    write_reg(lctw_pkg::REG_HALF_SPREAD, 16'd0);
    for (int i = 0; i < 5; i++) begin
      send_ready(24'($urandom));
      pause();
    end
    drain();
    write_reg(lctw_pkg::REG_TARE_COUNT, 16'd3);
    send_ready(24'($urandom));
    pause();
  endtask

  task automatic test_random_tare();
    int kind;
    int n;
    for (int a = 0; a < 30 && !measuring; a++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        collect_set(1'b1, 7'($urandom_range(1, 8)), 16'd0, PAT_NOISE, 0, 1'b0);
      end else if (kind <= 5) begin
        n = 2 * $urandom_range(1, 5);
        collect_set(1'b1, 7'(n), 16'($urandom), PAT_PAIRS, 0, 1'b0);
      end else if (kind <= 8) begin
        collect_set(1'b1, 7'($urandom_range(2, 8)), 16'($urandom_range(1, 2000)),
                    PAT_NOISE, 0, 1'b0);
      end else begin
        collect_set(1'b1, ($urandom_range(0, 1) == 0) ? 7'd64 : 7'd127,
                    16'($urandom_range(0, 300)), PAT_NOISE, 0, 1'b0);
      end
    end
  endtask

  task automatic test_tare_success();
    int tries;
    int n;
    longint base;
    tries = 0;
    while (!measuring) begin
      case ($urandom_range(0, 3))
        0: base = -8388608;
        1: base = 8388607;
        default: begin
          base = longint'($urandom_range(1000, 8000000));
          if ($urandom_range(0, 1) == 0) base = -base;
        end
      endcase
      n = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(2, 40);
      collect_set(1'b1, 7'(n), 16'($urandom_range(100, 5000)), PAT_CLUSTER, base,
                  tries < 3);
      tries++;
    end
  endtask

  task automatic test_weigh_extremes();
    logic signed [15:0] scales [5];
    scales[0] = 16'sd0;
    scales[1] = 16'sd1;
    scales[2] = -16'sd1;
    scales[3] = 16'sd32767;
    scales[4] = -16'sd32768;
    drain();
    // scale divisor still at its reset value here
    send_ready(24'h7FFFFF);
    send_ready(24'h800000);
    send_stale();
    for (int i = 0; i < 5; i++) begin
      drain();
      write_reg(lctw_pkg::REG_SCALE_DIVISOR, scales[i]);
      send_ready(24'h7FFFFF);
      pause();
      send_ready(24'h800000);
      pause();
    end
  endtask

  task automatic test_random_weigh();
    int len;
    logic signed [15:0] sc;
    while (items_sent < ITEM_TARGET) begin
      drain();
      case ($urandom_range(0, 9))
        0: sc = 16'sd0;
        1: sc = 16'sd1;
        2: sc = -16'sd1;
        3: sc = ($urandom_range(0, 1) == 0) ? 16'sd32767 : -16'sd32768;
        default: sc = 16'($urandom);
      endcase
      write_reg(lctw_pkg::REG_SCALE_DIVISOR, sc);
      // tare registers have no effect once measuring
      if ($urandom_range(0, 3) == 0) begin
        write_reg(lctw_pkg::REG_TARE_COUNT, 16'($urandom_range(0, 127)));
        write_reg(lctw_pkg::REG_HALF_SPREAD, 16'($urandom));
      end
      back_to_back = ($urandom_range(0, 3) == 0);
      len = $urandom_range(60, 120);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 59) == 0) drain();
        if ($urandom_range(0, 4) == 0) send_stale();
        else if ($urandom_range(0, 19) == 0)
          send_ready(($urandom_range(0, 1) == 0) ? 24'h7FFFFF : 24'h800000);
        else send_poll(8'd0, {16'($urandom), 32'($urandom)});
        pause();
      end
      back_to_back = 1'b0;
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_default_tare();
    test_frame_decode();
    test_count_zero();
    test_count_lowered();
    test_random_tare();
    test_tare_success();
    test_weigh_extremes();
    test_random_weigh();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
